// ===== src/tassg_pkg.sv =====
// Shared constants, codes and types of the three-axis segment step generator.
package tassg_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int AXES    = 3;
  localparam int DELTA_W = 32;
  localparam int DUR_W   = 32;
  localparam int POS_W   = 48;
  localparam int TICKS_W = 29;
  localparam int ACC_W   = 33;
  localparam int MAG_W   = 32;
  localparam int LEVEL_W = 5;
  localparam int MODE_W  = 2;
  localparam int FUNC_W  = 2;

  // divide by 10 us: x / 10 == (x * 0xCCCCCCCD) >> 35 for any 32-bit x
  localparam logic [DUR_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;
  localparam int               PROD_W      = 2 * DUR_W;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MODE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_POS  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_DISARMED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARMED    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUNNING  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FAULT    = 2'd3;

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_FAULT,
    CMD_PUSH,
    CMD_MODE,
    CMD_POS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                         kind;
    logic [AXES-1:0][DELTA_W-1:0]      delta;
    logic [DUR_W-1:0]                  dur;
    logic [MODE_W-1:0]                 new_mode;
    logic [AXES-1:0][POS_W-1:0]        set_pos;
  } cmd_t;

  typedef struct packed {
    logic [DUR_W-1:0]                  dur;
    logic [AXES-1:0][DELTA_W-1:0]      delta;
  } seg_t;

endpackage

// ===== src/three_axis_segment_step_generator.sv =====
// Top level of the three-axis segment step generator.
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  ---------------------------------------------
//  in       in   in_valid_i/in_stall_o   func, deltas, duration, mode, set pos, inputs
//  out      out  out_valid_o/out_stall_i step pulses, dirs, mode, level, flags, pos
//
//  Steps: a request passes the front end and the command queue; the back end
//  ends push, set mode, set position, fault, non-running and empty-store ticks
//  in its idle state, a tick on an active segment by issue, accumulate, fire,
//  a tick that pops a new segment by store read, x/10 multiply, setup,
//  accumulate, fire. The back end runs one request at a time.
//  Reset: async, active low; mode disarmed, store empty, positions zero, dirs
//  forward. The segment store itself is not cleared.
//  Stalls: a two-entry command queue takes requests while a result waits in
//  the output register; a held result blocks only the back end.
module three_axis_segment_step_generator import tassg_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic signed [DELTA_W-1:0] delta_x_i,
  input  logic signed [DELTA_W-1:0] delta_y_i,
  input  logic signed [DELTA_W-1:0] delta_z_i,
  input  logic [DUR_W-1:0]          duration_us_i,
  input  logic [MODE_W-1:0]         new_mode_i,
  input  logic signed [POS_W-1:0]   set_x_i,
  input  logic signed [POS_W-1:0]   set_y_i,
  input  logic signed [POS_W-1:0]   set_z_i,
  input  logic                      estop_n_i,
  input  logic [AXES-1:0]           limits_n_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [AXES-1:0]           step_pulses_o,
  output logic [AXES-1:0]           dir_bits_o,
  output logic [MODE_W-1:0]         mode_now_o,
  output logic [LEVEL_W-1:0]        queue_level_o,
  output logic                      push_ok_o,
  output logic                      segment_busy_o,
  output logic signed [POS_W-1:0]   position_x_o,
  output logic signed [POS_W-1:0]   position_y_o,
  output logic signed [POS_W-1:0]   position_z_o
);

  // front end to queue
  logic q_full, q_push;
  cmd_t q_cmd_in;

  // queue to back end
  logic q_valid, q_pop;
  cmd_t q_cmd_out;

  // classify: e-stop and limits are folded into a fault command here, so the
  // back end never looks at the raw switch inputs
  tassg_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .delta_z_i     (delta_z_i),
    .duration_us_i (duration_us_i),
    .new_mode_i    (new_mode_i),
    .set_x_i       (set_x_i),
    .set_y_i       (set_y_i),
    .set_z_i       (set_z_i),
    .estop_n_i     (estop_n_i),
    .limits_n_i    (limits_n_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd_in)
  );

  // decoupling queue, keeps requests in order
  tassg_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  // execution: segment ring store, modes, DDA per axis, result register
  tassg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd_out),
    .cmd_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_pulses_o  (step_pulses_o),
    .dir_bits_o     (dir_bits_o),
    .mode_now_o     (mode_now_o),
    .queue_level_o  (queue_level_o),
    .push_ok_o      (push_ok_o),
    .segment_busy_o (segment_busy_o),
    .position_x_o   (position_x_o),
    .position_y_o   (position_y_o),
    .position_z_o   (position_z_o)
  );

endmodule

// ===== src/tassg_front.sv =====
// Front end: takes requests and classifies them into commands for the queue.
module tassg_front import tassg_pkg::*; (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic signed [DELTA_W-1:0] delta_x_i,
  input  logic signed [DELTA_W-1:0] delta_y_i,
  input  logic signed [DELTA_W-1:0] delta_z_i,
  input  logic [DUR_W-1:0]          duration_us_i,
  input  logic [MODE_W-1:0]         new_mode_i,
  input  logic signed [POS_W-1:0]   set_x_i,
  input  logic signed [POS_W-1:0]   set_y_i,
  input  logic signed [POS_W-1:0]   set_z_i,
  input  logic                      estop_n_i,
  input  logic [AXES-1:0]           limits_n_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output cmd_t                      q_cmd_o
);

  logic trip;

  // e-stop or any limit switch pulled low
  assign trip = !estop_n_i || (limits_n_i != {AXES{1'b1}});

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.delta    = {delta_z_i, delta_y_i, delta_x_i};
    q_cmd_o.dur      = duration_us_i;
    q_cmd_o.new_mode = new_mode_i;
    q_cmd_o.set_pos  = {set_z_i, set_y_i, set_x_i};
    case (func_i)
      FUNC_TICK: q_cmd_o.kind = trip ? CMD_FAULT : CMD_TICK;
      FUNC_PUSH: q_cmd_o.kind = CMD_PUSH;
      FUNC_MODE: q_cmd_o.kind = CMD_MODE;
      FUNC_POS:  q_cmd_o.kind = CMD_POS;
      default:   q_cmd_o.kind = CMD_TICK;
    endcase
  end

endmodule

// ===== src/tassg_cmdq.sv =====
// Two-entry command queue between the front end and the execution back end.
module tassg_cmdq import tassg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/tassg_back.sv =====
// Back end: segment store, mode control, DDA axes and the result register.
module tassg_back import tassg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  cmd_t                     cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [AXES-1:0]          step_pulses_o,
  output logic [AXES-1:0]          dir_bits_o,
  output logic [MODE_W-1:0]        mode_now_o,
  output logic [LEVEL_W-1:0]       queue_level_o,
  output logic                     push_ok_o,
  output logic                     segment_busy_o,
  output logic signed [POS_W-1:0]  position_x_o,
  output logic signed [POS_W-1:0]  position_y_o,
  output logic signed [POS_W-1:0]  position_z_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_FIRE  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic                active_q, active_d;
  logic [TICKS_W-1:0]  ticks_total_q, ticks_total_d;
  logic [TICKS_W-1:0]  ticks_done_q, ticks_done_d;
  logic [TICKS_W-1:0]  ticks_raw, done_inc;
  logic [MAG_W-1:0]    mag_q [AXES];
  logic [MAG_W-1:0]    mag_d [AXES];
  logic [ACC_W-1:0]    acc_q [AXES];
  logic [ACC_W-1:0]    acc_d [AXES];
  logic [ACC_W:0]      acc_sum [AXES];
  logic [AXES-1:0]     dir_q, dir_d;
  logic [POS_W-1:0]    pos_q [AXES];
  logic [POS_W-1:0]    pos_d [AXES];
  logic [PROD_W-1:0]   prod_q, prod_d;

  seg_t                seg_mem [QUEUE_DEPTH];
  seg_t                seg_q;
  logic                mem_wr, mem_rd;

  logic                out_ready, finish, clear, pushed;
  logic [AXES-1:0]     pulses;
  logic                out_valid_q;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

  // result slot is free now or is being taken this cycle
  assign out_ready = !out_valid_q || !out_stall_i;
  assign ticks_raw = prod_q[RECIP_SHIFT +: TICKS_W];
  assign done_inc  = ticks_done_q + 1'b1;

  always_comb begin
    state_d       = state_q;
    wr_idx_d      = wr_idx_q;
    rd_idx_d      = rd_idx_q;
    count_d       = count_q;
    mode_d        = mode_q;
    active_d      = active_q;
    ticks_total_d = ticks_total_q;
    ticks_done_d  = ticks_done_q;
    dir_d         = dir_q;
    prod_d        = prod_q;
    mag_d         = mag_q;
    acc_d         = acc_q;
    pos_d         = pos_q;
    pulses        = '0;
    pushed        = 1'b0;
    finish        = 1'b0;
    clear         = 1'b0;
    cmd_pop_o     = 1'b0;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      acc_sum[i] = {1'b0, acc_q[i]} + {2'b00, mag_q[i]};
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_TICK: begin
              if (mode_q != MODE_RUNNING) begin
                if (out_ready) begin
                  cmd_pop_o = 1'b1;
                  finish    = 1'b1;
                end
              end else if (active_q) begin
                cmd_pop_o = 1'b1;
                state_d   = S_ACC;
              end else if (count_q == '0) begin
                if (out_ready) begin
                  cmd_pop_o = 1'b1;
                  finish    = 1'b1;
                  mode_d    = MODE_ARMED;
                end
              end else begin
                cmd_pop_o = 1'b1;
                mem_rd    = 1'b1;
                rd_idx_d  = next_idx(rd_idx_q);
                count_d   = count_q - 1'b1;
                active_d  = 1'b1;
                state_d   = S_MUL;
              end
            end
            CMD_FAULT: begin
              if (out_ready) begin
                cmd_pop_o = 1'b1;
                finish    = 1'b1;
                mode_d    = MODE_FAULT;
                clear     = 1'b1;
              end
            end
            CMD_PUSH: begin
              if (out_ready) begin
                cmd_pop_o = 1'b1;
                finish    = 1'b1;
                if (count_q < CNT_W'(QUEUE_DEPTH)) begin
                  mem_wr   = 1'b1;
                  wr_idx_d = next_idx(wr_idx_q);
                  count_d  = count_q + 1'b1;
                  pushed   = 1'b1;
                end
              end
            end
            CMD_MODE: begin
              if (out_ready) begin
                cmd_pop_o = 1'b1;
                finish    = 1'b1;
                mode_d    = cmd_i.new_mode;
                clear     = cmd_i.new_mode inside {MODE_DISARMED, MODE_FAULT};
              end
            end
            CMD_POS: begin
              if (out_ready) begin
                cmd_pop_o = 1'b1;
                finish    = 1'b1;
                for (int i = 0; i < AXES; i++) begin
                  pos_d[i] = cmd_i.set_pos[i];
                end
              end
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      S_MUL: begin
        prod_d  = seg_q.dur * RECIP_TEN;
        state_d = S_SETUP;
      end
      S_SETUP: begin
        ticks_total_d = (ticks_raw == '0) ? TICKS_W'(1) : ticks_raw;
        ticks_done_d  = '0;
        for (int i = 0; i < AXES; i++) begin
          dir_d[i] = !seg_q.delta[i][DELTA_W-1];
          mag_d[i] = seg_q.delta[i][DELTA_W-1] ? (~seg_q.delta[i] + 1'b1) : seg_q.delta[i];
          acc_d[i] = '0;
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        for (int i = 0; i < AXES; i++) begin
          if (mag_q[i] != '0) begin
            acc_d[i] = acc_sum[i][ACC_W] ? ACC_MAX : acc_sum[i][ACC_W-1:0];
          end
        end
        state_d = S_FIRE;
      end
      S_FIRE: begin
        if (out_ready) begin
          for (int i = 0; i < AXES; i++) begin
            if ((mag_q[i] != '0) && (acc_q[i] >= ACC_W'(ticks_total_q))) begin
              acc_d[i]  = acc_q[i] - ACC_W'(ticks_total_q);
              pulses[i] = 1'b1;
              if (dir_q[i]) begin
                if (pos_q[i] != POS_MAX) pos_d[i] = pos_q[i] + 1'b1;
              end else begin
                if (pos_q[i] != POS_MIN) pos_d[i] = pos_q[i] - 1'b1;
              end
            end
          end
          ticks_done_d = done_inc;
          if (done_inc >= ticks_total_q) active_d = 1'b0;
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // dropping to disarmed or fault empties the store and ends the segment
    if (clear) begin
      wr_idx_d = '0;
      rd_idx_d = '0;
      count_d  = '0;
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wr_idx_q      <= '0;
      rd_idx_q      <= '0;
      count_q       <= '0;
      mode_q        <= MODE_DISARMED;
      active_q      <= 1'b0;
      ticks_total_q <= '0;
      ticks_done_q  <= '0;
      dir_q         <= {AXES{1'b1}};
      out_valid_q   <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        mag_q[i] <= '0;
        acc_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      state_q       <= state_d;
      wr_idx_q      <= wr_idx_d;
      rd_idx_q      <= rd_idx_d;
      count_q       <= count_d;
      mode_q        <= mode_d;
      active_q      <= active_d;
      ticks_total_q <= ticks_total_d;
      ticks_done_q  <= ticks_done_d;
      dir_q         <= dir_d;
      mag_q         <= mag_d;
      acc_q         <= acc_d;
      pos_q         <= pos_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // segment store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      seg_mem[wr_idx_q] <= {cmd_i.dur, cmd_i.delta};
    end
    if (mem_rd) begin
      seg_q <= seg_mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (finish) begin
      step_pulses_o  <= pulses;
      dir_bits_o     <= dir_d;
      mode_now_o     <= mode_d;
      queue_level_o  <= LEVEL_W'(count_d);
      push_ok_o      <= pushed;
      segment_busy_o <= active_d;
      position_x_o   <= pos_d[0];
      position_y_o   <= pos_d[1];
      position_z_o   <= pos_d[2];
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("segment count above store depth");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished request left no result");

  a_idle_modes_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_FAULT || mode_q == MODE_DISARMED) |-> !active_q)
    else $error("segment active while disarmed or faulted");

  a_busy_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> active_q)
    else $error("tick sequence running without an active segment");

  a_ticks_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && active_q) |-> (ticks_done_q < ticks_total_q))
    else $error("active segment has no ticks left");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the three-axis segment step generator.
`timescale 1ns / 1ps

module testbench;
  import tassg_pkg::*;

  localparam logic [DUR_W-1:0] TICK_US = 10;  // one tick stands for 10 us
  localparam int TARGET_REQUESTS = 680;        // directed part plus about 650 random
  localparam int CALM_TAIL = 120;              // last requests run without idling
  localparam int SETTLE_CYCLES = 20;           // well past the deepest back-end path
  localparam int MAX_REPORTS = 200;

  // One request as the sender presents it; axis 0 is X.
  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic [AXES-1:0][DELTA_W-1:0] delta;
    logic [DUR_W-1:0]             dur;
    logic [MODE_W-1:0]            mode;
    logic [AXES-1:0][POS_W-1:0]   set_pos;
    logic                         estop_n;
    logic [AXES-1:0]              limits_n;
  } request_t;

  // One status word as the block returns it.
  typedef struct packed {
    logic [AXES-1:0]            pulses;
    logic [AXES-1:0]            dirs;
    logic [MODE_W-1:0]          mode;
    logic [LEVEL_W-1:0]         level;
    logic                       push_ok;
    logic                       busy;
    logic [AXES-1:0][POS_W-1:0] pos;
  } status_t;

  // Motion predictor plus the queue of status words still owed by the block.
  class motion_scoreboard;
    seg_t               seg_store [QUEUE_DEPTH];
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   count;
    logic [MODE_W-1:0]  mode;
    bit                 busy;
    logic [TICKS_W-1:0] ticks_total;
    logic [TICKS_W-1:0] ticks_done;
    logic [MAG_W-1:0]   mag [AXES];
    logic [ACC_W-1:0]   acc [AXES];
    logic [AXES-1:0]    dirs;
    logic [POS_W-1:0]   pos [AXES];
    status_t            expected_status [$];
    int requests, checked, errors, pulses_seen, refused_pushes, fault_trips;

    function new();
      wr_idx = '0;
      rd_idx = '0;
      count = '0;
      mode = MODE_DISARMED;
      busy = 1'b0;
      ticks_total = '0;
      ticks_done = '0;
      dirs = '1;
      for (int i = 0; i < AXES; i++) begin
        mag[i] = '0;
        acc[i] = '0;
        pos[i] = '0;
      end
    endfunction

    function void change_mode(logic [MODE_W-1:0] m);
      mode = m;
      if (m == MODE_DISARMED || m == MODE_FAULT) begin
        wr_idx = '0;
        rd_idx = '0;
        count = '0;
        busy = 1'b0;
      end
    endfunction

    // One running tick: pop a segment if idle, then step the three DDAs.
    function logic [AXES-1:0] run_tick();
      seg_t             s;
      logic [AXES-1:0]  fired;
      logic [ACC_W:0]   sum;
      logic [DUR_W-1:0] q;
      fired = '0;
      if (mode != MODE_RUNNING) return fired;
      if (!busy) begin
        if (count == 0) begin
          change_mode(MODE_ARMED);
          return fired;
        end
        s = seg_store[rd_idx];
        rd_idx = rd_idx + 1'b1;
        count = count - 1'b1;
        busy = 1'b1;
        q = s.dur / TICK_US;
        ticks_total = (q == 0) ? TICKS_W'(1) : q[TICKS_W-1:0];
        ticks_done = '0;
        dirs = '0;
        for (int i = 0; i < AXES; i++) begin
          if (s.delta[i][DELTA_W-1]) begin
            mag[i] = '0 - s.delta[i];
          end else begin
            mag[i] = s.delta[i];
            dirs[i] = 1'b1;
          end
          acc[i] = '0;
        end
      end
      for (int i = 0; i < AXES; i++) begin
        if (mag[i] != '0) begin
          sum = {1'b0, acc[i]} + mag[i];
          acc[i] = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
          if (acc[i] >= ticks_total) begin
            acc[i] = acc[i] - ticks_total;
            if (dirs[i]) begin
              if (pos[i] != POS_MAX) pos[i] = pos[i] + 1'b1;
            end else if (pos[i] != POS_MIN) begin
              pos[i] = pos[i] - 1'b1;
            end
            fired[i] = 1'b1;
          end
        end
      end
      ticks_done = ticks_done + 1'b1;
      if (ticks_done >= ticks_total) busy = 1'b0;
      return fired;
    endfunction

    function void note_request(request_t r);
      status_t st;
      st = '0;
      requests++;
      case (r.func)
        FUNC_TICK: begin
          if (!r.estop_n || r.limits_n != '1) begin
            change_mode(MODE_FAULT);
            fault_trips++;
          end else begin
            st.pulses = run_tick();
          end
        end
        FUNC_PUSH: begin
          if (count < QUEUE_DEPTH) begin
            seg_store[wr_idx].dur = r.dur;
            seg_store[wr_idx].delta = r.delta;
            wr_idx = wr_idx + 1'b1;
            count = count + 1'b1;
            st.push_ok = 1'b1;
          end else begin
            refused_pushes++;
          end
        end
        FUNC_MODE: change_mode(r.mode);
        default: begin
          for (int i = 0; i < AXES; i++) pos[i] = r.set_pos[i];
        end
      endcase
      st.dirs = dirs;
      st.mode = mode;
      st.level = count;
      st.busy = busy;
      for (int i = 0; i < AXES; i++) st.pos[i] = pos[i];
      expected_status.push_back(st);
    endfunction

    function void compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t  %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t  unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = expected_status.pop_front();
      checked++;
      pulses_seen += $countones(got.pulses);
      compare_field("step_pulses", want.pulses, got.pulses);
      compare_field("dir_bits", want.dirs, got.dirs);
      compare_field("mode_now", want.mode, got.mode);
      compare_field("queue_level", want.level, got.level);
      compare_field("push_ok", want.push_ok, got.push_ok);
      compare_field("segment_busy", want.busy, got.busy);
      for (int i = 0; i < AXES; i++)
        compare_field($sformatf("position axis %0d", i), want.pos[i], got.pos[i]);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [FUNC_W-1:0]         func_i = FUNC_TICK;
  logic signed [DELTA_W-1:0] delta_x_i = '0;
  logic signed [DELTA_W-1:0] delta_y_i = '0;
  logic signed [DELTA_W-1:0] delta_z_i = '0;
  logic [DUR_W-1:0]          duration_us_i = '0;
  logic [MODE_W-1:0]         new_mode_i = MODE_DISARMED;
  logic signed [POS_W-1:0]   set_x_i = '0;
  logic signed [POS_W-1:0]   set_y_i = '0;
  logic signed [POS_W-1:0]   set_z_i = '0;
  logic                      estop_n_i = 1'b1;
  logic [AXES-1:0]           limits_n_i = '1;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [AXES-1:0]           step_pulses_o;
  logic [AXES-1:0]           dir_bits_o;
  logic [MODE_W-1:0]         mode_now_o;
  logic [LEVEL_W-1:0]        queue_level_o;
  logic                      push_ok_o;
  logic                      segment_busy_o;
  logic signed [POS_W-1:0]   position_x_o;
  logic signed [POS_W-1:0]   position_y_o;
  logic signed [POS_W-1:0]   position_z_o;

  status_t          seen;
  motion_scoreboard sb;
  bit               idle_on = 1'b1;
  int               stall_left = 0;

  three_axis_segment_step_generator uut (.*);

  assign seen = {step_pulses_o, dir_bits_o, mode_now_o, queue_level_o, push_ok_o,
                 segment_busy_o, position_z_o, position_y_o, position_x_o};

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result side: check what was taken at this edge, then pick the next stall level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_status(seen);
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_stall_i <= (stall_left > 0);
  end

  function automatic logic [POS_W-1:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  // Positions: mostly anywhere, sometimes right against a bound.
  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return POS_MAX - POS_W'($urandom_range(0, 3));
      1: return POS_MIN + POS_W'($urandom_range(0, 3));
      default: return rand48();
    endcase
  endfunction

  // Deltas scaled to the segment length so that axes move, with the odd full-range one.
  function automatic logic [DELTA_W-1:0] pick_delta(int unsigned ticks);
    int unsigned span;
    if (ticks > 1000) return $urandom();
    span = 3 * ticks + 2;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return '0;
      default: return DELTA_W'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  // Every field random; the e-stop and limits released unless overridden.
  function automatic request_t random_request();
    request_t r;
    r.func = FUNC_W'($urandom_range(0, 3));
    r.delta = {$urandom(), $urandom(), $urandom()};
    r.dur = $urandom();
    r.mode = MODE_W'($urandom_range(0, 3));
    for (int i = 0; i < AXES; i++) r.set_pos[i] = rand48();
    r.estop_n = 1'b1;
    r.limits_n = '1;
    return r;
  endfunction

  function automatic request_t tick_req(logic estop_n, logic [AXES-1:0] limits_n);
    request_t r;
    r = random_request();
    r.func = FUNC_TICK;
    r.estop_n = estop_n;
    r.limits_n = limits_n;
    return r;
  endfunction

  function automatic request_t push_req(logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                                        logic [DELTA_W-1:0] dz, logic [DUR_W-1:0] dur);
    request_t r;
    r = random_request();
    r.func = FUNC_PUSH;
    r.delta = {dz, dy, dx};
    r.dur = dur;
    return r;
  endfunction

  function automatic request_t mode_req(logic [MODE_W-1:0] m);
    request_t r;
    r = random_request();
    r.func = FUNC_MODE;
    r.mode = m;
    return r;
  endfunction

  function automatic request_t pos_req(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                       logic [POS_W-1:0] z);
    request_t r;
    r = random_request();
    r.func = FUNC_POS;
    r.set_pos = {z, y, x};
    return r;
  endfunction

  // Present one request, with an occasional random gap first, and hold it until taken.
  task automatic send_request(request_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= r.func;
    delta_x_i <= r.delta[0];
    delta_y_i <= r.delta[1];
    delta_z_i <= r.delta[2];
    duration_us_i <= r.dur;
    new_mode_i <= r.mode;
    set_x_i <= r.set_pos[0];
    set_y_i <= r.set_pos[1];
    set_z_i <= r.set_pos[2];
    estop_n_i <= r.estop_n;
    limits_n_i <= r.limits_n;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  // Sender holds off until every owed status word has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_status.size() != 0);
  endtask

  task automatic push_short(int unsigned max_us);
    int unsigned dur;
    dur = ($urandom_range(0, 24) == 0) ? $urandom() : $urandom_range(0, max_us);
    send_request(push_req(pick_delta(dur / TICK_US + 1), pick_delta(dur / TICK_US + 1),
                          pick_delta(dur / TICK_US + 1), dur));
  endtask

  // Run until the queue drains to armed, with the odd fault, push or reposition mid-run.
  task automatic run_queue();
    int guard;
    guard = 0;
    send_request(mode_req(MODE_RUNNING));
    while (sb.mode == MODE_RUNNING && guard < 150) begin
      guard++;
      case ($urandom_range(0, 59))
        0: send_request(tick_req(1'b0, AXES'($urandom_range(0, 7))));
        1: send_request(tick_req(1'b1, AXES'($urandom_range(0, 6))));
        2, 3: send_request(pos_req(pick_pos(), pick_pos(), pick_pos()));
        4, 5: push_short(90);
        6: send_request(mode_req(MODE_ARMED));
        default: send_request(tick_req(1'b1, '1));
      endcase
    end
    // a fault must survive a released tick; then leave it by a mode request
    if (sb.mode != MODE_ARMED) begin
      send_request(tick_req(1'b1, '1));
      send_request(mode_req(($urandom_range(0, 1) != 0) ? MODE_ARMED : MODE_DISARMED));
    end
  endtask

  task automatic motion_program();
    if ($urandom_range(0, 3) == 0) send_request(pos_req(pick_pos(), pick_pos(), pick_pos()));
    repeat ($urandom_range(1, 4)) push_short(90);
    run_queue();
  endtask

  // Fill the queue, often past its depth so that late pushes are refused, then run or drop it.
  task automatic fill_queue();
    repeat ($urandom_range(12, 20)) push_short(40);
    if ($urandom_range(0, 1) != 0) run_queue();
    else send_request(mode_req(MODE_DISARMED));
  endtask

  task automatic send_noise();
    request_t r;
    r = random_request();
    if ($urandom_range(0, 5) == 0) r.estop_n = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 5) == 0) r.limits_n = AXES'($urandom_range(0, 7));
    send_request(r);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short and extreme segments, fast axes, mode rules.
    send_request(push_req(32'd5, -32'sd3, 32'd0, 32'd0));            // under one tick
    send_request(push_req(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd9)); // most negative
    send_request(push_req(32'd3, -32'sd7, 32'd10, 32'd50));
    send_request(mode_req(MODE_ARMED));                              // queue kept
    send_request(mode_req(MODE_RUNNING));
    repeat (8) send_request(tick_req(1'b1, '1));                     // last one drops to armed
    send_request(pos_req(POS_MAX - 1'b1, POS_MIN + 1'b1, '0));
    send_request(push_req(32'd4, -32'sd4, 32'd0, 32'd20));            // runs into the bounds
    send_request(push_req(32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF));       // longest duration
    send_request(mode_req(MODE_RUNNING));
    repeat (3) send_request(tick_req(1'b1, '1));
    send_request(pos_req('0, '0, '0));                               // segment carries on
    send_request(tick_req(1'b0, '1));                                // e-stop
    send_request(tick_req(1'b1, '1));                                // fault holds
    send_request(push_req(32'd2, 32'd2, 32'd2, 32'd30));             // push while in fault
    send_request(tick_req(1'b1, 3'b101));                            // Y limit
    send_request(mode_req(MODE_DISARMED));
    wait_for_results();

    // Random: mostly complete motion programs, some overfills, pauses and noise.
    while (sb.requests < TARGET_REQUESTS) begin
      if (sb.requests > TARGET_REQUESTS - CALM_TAIL) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: motion_program();
        6: fill_queue();
        7: wait_for_results();
        default: send_noise();
      endcase
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests and checked %0d results: %0d step pulses,",
             sb.requests, sb.checked, sb.pulses_seen);
    $display("%0d pushes refused on a full queue, %0d fault trips from e-stop or limits.",
             sb.refused_pushes, sb.fault_trips);
    if (sb.errors == 0 && sb.expected_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/tassg_pkg.sv
src/tassg_front.sv
src/tassg_cmdq.sv
src/tassg_back.sv
src/three_axis_segment_step_generator.sv
verif/testbench.sv
